@@ rtl/core/sis_pkg.sv @@
// sis_pkg: shared types and codes for the sorted insert stack
// no dependencies
`timescale 1ns / 1ps

package sis_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   // broadcast to every cell for one beat
   typedef struct packed {
      logic      insert;
      logic      pop;
      value_type value;
   } sis_ctl_type;

endpackage

@@ rtl/core/sis_cell.sv @@
// sis_cell: one slot of the sorted row, largest values toward cell 0
// depends on sis_pkg
`timescale 1ns / 1ps

module sis_cell
   import sis_pkg::*;
(
   input  logic        clock,
   input  sis_ctl_type ctl,
   input  logic        occupied,
   input  logic        lower_ge,
   input  value_type   lower_entry,
   input  value_type   upper_entry,
   output logic        ge,
   output value_type   entry
);

   value_type entry_ff;
   value_type entry_in;

   assign ge    = occupied && !(entry_ff < ctl.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = upper_entry;
      end else if (ctl.insert && !ge) begin
         if (lower_ge) begin
            entry_in = ctl.value;
         end else begin
            entry_in = lower_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/core/sorted_insert_stack.sv @@
// sorted_insert_stack: top level, a row of sis_cell slots plus fill count and result register
// depends on sis_pkg and sis_cell
`timescale 1ns / 1ps
//
//  channel   ports                                   handshake
//  request   req_command, req_value                  start & !busy
//  response  rsp_popped_value, rsp_status,           rsp_valid, one cycle
//            rsp_entry_count
//
//  one beat per clock; busy stays low, the cell row updates in the cycle of the beat
//  the result appears the cycle after its beat, for exactly one cycle
//  reset clears the fill count and the strobe; cell contents are left as they are
//  the receiver cannot stall, so nothing holds results back

module sorted_insert_stack
   import sis_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic signed [31:0] req_value,
   output logic              rsp_valid,
   output logic signed [31:0] rsp_popped_value,
   output logic [1:0]        rsp_status,
   output logic [6:0]        rsp_entry_count
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          valid_ff;
   value_type     popped_ff;
   value_type     popped_in;
   logic [1:0]    status_ff;
   logic [1:0]    status_in;

   logic        accept;
   logic        full;
   logic        empty;
   sis_ctl_type ctl;

   logic      ge_row    [DEPTH];
   value_type entry_row [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctl.insert = accept && (req_command == CMD_INSERT) && !full;
   assign ctl.pop    = accept && (req_command == CMD_POP) && !empty;
   assign ctl.value  = req_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      lower_ge;
      value_type lower_entry;
      value_type upper_entry;
      if (i == 0) begin : g_first
         assign lower_ge    = 1'b1;
         assign lower_entry = ctl.value;
      end else begin : g_rest
         assign lower_ge    = ge_row[i-1];
         assign lower_entry = entry_row[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper_entry = '0;
      end else begin : g_inner
         assign upper_entry = entry_row[i+1];
      end
      sis_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (CW'(i) < count_ff),
         .lower_ge    (lower_ge),
         .lower_entry (lower_entry),
         .upper_entry (upper_entry),
         .ge          (ge_row[i]),
         .entry       (entry_row[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      status_in = STATUS_OK;
      if (accept) begin
         if (req_command == CMD_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in  = count_ff - CW'(1);
               popped_in = entry_row[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accept;
      end
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   logic [CW+6:0] count_ext;
   assign count_ext = {7'b0, count_ff};

   assign rsp_valid        = valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = count_ext[6:0];

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_strobe_follows_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing response strobe");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_INSERT && full) |=> (count_ff == CW'(DEPTH)))
      else $error("dropped insert changed the count");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_popped_value == 0))
      else $error("empty pop returned data");
`endif

endmodule

@@ tb/sorted_insert_stack_test.sv @@
// sorted_insert_stack_test: self-checking bench for the sorted insert stack, with a scoreboard
// class that predicts each result and plain tasks that drive insert and pop beats
// depends on sis_pkg and sorted_insert_stack
`timescale 1ns / 1ps

module sorted_insert_stack_test
   import sis_pkg::*;
();

   localparam int unsigned STORE_DEPTH  = 64;
   localparam int unsigned RANDOM_ITEMS = 1850;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;

   typedef enum int unsigned {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_type;

   typedef struct {
      value_type          popped;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   class stack_board;
      value_type     entries[STORE_DEPTH];
      int unsigned   fill;
      outcome_type   awaited[$];
      int unsigned   errors;
      int unsigned   inserts;
      int unsigned   pops;
      int unsigned   full_hits;
      int unsigned   empty_hits;

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // ordered insert below every entry >= value, pop from the top
      function void note_beat(logic cmd, value_type val);
         outcome_type o;
         int unsigned pos;
         int unsigned i;
         o.popped = '0;
         o.status = STATUS_OK;
         if (cmd == CMD_INSERT) begin
            inserts++;
            if (fill >= STORE_DEPTH) begin
               o.status = STATUS_FULL;
               full_hits++;
            end else begin
               pos = 0;
               while (pos < fill && entries[pos] < val) pos++;
               for (i = fill; i > pos; i--) entries[i] = entries[i-1];
               entries[pos] = val;
               fill++;
            end
         end else begin
            pops++;
            if (fill == 0) begin
               o.status = STATUS_EMPTY;
               empty_hits++;
            end else begin
               fill--;
               o.popped = entries[fill];
            end
         end
         o.count = COUNT_W'(fill);
         awaited.push_back(o);
      endfunction

      task check_result(value_type popped, logic [1:0] status, logic [COUNT_W-1:0] count);
         outcome_type o;
         if (awaited.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            o = awaited.pop_front();
            if (popped !== o.popped)
               report($sformatf("popped_value %0d, expected %0d", popped, o.popped));
            if (status !== o.status)
               report($sformatf("status %0d, expected %0d", status, o.status));
            if (count !== o.count)
               report($sformatf("entry_count %0d, expected %0d", count, o.count));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = CMD_INSERT;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_popped_value;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_entry_count;

   stack_board  sb = new();
   int unsigned cycles = 0;
   int unsigned beats_sent = 0;

   sorted_insert_stack #(.DEPTH(STORE_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_popped_value, rsp_status, rsp_entry_count);
         if (start && !busy) sb.note_beat(req_command, req_value);
      end
   end

   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return VALUE_MAX;
               1: return VALUE_MIN;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         1, 2, 3: return value_type'($urandom_range(0, 16)) - 8;
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic idle_gap(bit quiet);
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) gap = 0;
      else if (roll < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap != 0) begin
         start       <= 1'b0;
         req_command <= 1'($urandom);
         req_value   <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_beat(logic cmd, value_type val, bit quiet);
      if (beats_sent != 0) idle_gap(quiet);
      req_command <= cmd;
      req_value   <= val;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      beats_sent++;
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned span;
      int unsigned k;
      int unsigned pop_pct;
      phase_type   phase;
      bit          quiet;
      logic        cmd;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty pops, extremes, ties, then drain past empty
      send_beat(CMD_POP, VALUE_MAX, 1'b0);
      send_beat(CMD_POP, VALUE_MIN, 1'b0);
      send_beat(CMD_INSERT, 0, 1'b0);
      send_beat(CMD_INSERT, VALUE_MAX, 1'b0);
      send_beat(CMD_INSERT, VALUE_MIN, 1'b0);
      send_beat(CMD_INSERT, -1, 1'b0);
      send_beat(CMD_INSERT, 1, 1'b0);
      send_beat(CMD_INSERT, 0, 1'b0);
      send_beat(CMD_INSERT, VALUE_MAX, 1'b0);
      send_beat(CMD_INSERT, VALUE_MIN, 1'b0);
      for (k = 0; k < 9; k++) send_beat(CMD_POP, pick_value(), 1'b0);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         span  = $urandom_range(20, 120);
         phase = phase_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 3) == 0);
         case (phase)
            FILL_PHASE:  pop_pct = 12;
            DRAIN_PHASE: pop_pct = 88;
            default:     pop_pct = 50;
         endcase
         for (k = 0; k < span && random_sent < RANDOM_ITEMS; k++) begin
            cmd = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_INSERT;
            send_beat(cmd, pick_value(), quiet);
            random_sent++;
         end
      end
      start <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d inserts (%0d dropped on a full store) and %0d pops",
               sb.inserts, sb.full_hits, sb.pops);
      $display("of the pops %0d hit an empty store; %0d mismatches", sb.empty_hits, sb.errors);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
